// File: src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Shared types and constants for the text console character writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CURSOR_W   = 11;
    localparam int CELL_W     = 16;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0FFF;

    // Operation decoded from one character request.
    typedef enum logic [2:0] {
        OP_PRINT,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_RETURN,
        OP_IGNORE
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [CHAR_W-1:0] code;
    } cmd_t;

    // Status from the execution side back to the front end.
    typedef struct packed {
        logic clearing;
        logic busy;
    } back_status_t;

endpackage : tcw_pkg

`default_nettype wire

// File: src/tcw_front.sv
// ----------------------------------------------------------------------------
// Text console writer front end
// Accepts character requests, decodes them and hands them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [tcw_pkg::CHAR_W-1:0] s_char_code,
    input  wire tcw_pkg::back_status_t      status,
    output logic                            push_valid,
    input  wire logic                       push_ready,
    output tcw_pkg::cmd_t                   push_cmd
);
    import tcw_pkg::*;

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_cmd_reg;
    cmd_t hold_cmd_next;
    cmd_t decoded;

    always_comb begin
        decoded.code = s_char_code;
        unique case (s_char_code)
            CH_NEWLINE:   decoded.op = OP_NEWLINE;
            CH_BACKSPACE: decoded.op = OP_BACKSPACE;
            CH_RETURN:    decoded.op = OP_RETURN;
            CH_TAB:       decoded.op = OP_IGNORE;
            default:      decoded.op = OP_PRINT;
        endcase
    end

    // No request is taken while the screen is being cleared after reset.
    assign s_ready    = !status.clearing && (!hold_valid_reg || push_ready);
    assign push_valid = hold_valid_reg;
    assign push_cmd   = hold_cmd_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_cmd_next   = hold_cmd_reg;
        if (push_ready) begin
            hold_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            hold_valid_next = 1'b1;
            hold_cmd_next   = decoded;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        hold_cmd_reg <= hold_cmd_next;
    end

endmodule : tcw_front

`default_nettype wire

// File: src/tcw_queue.sv
// ----------------------------------------------------------------------------
// Text console writer command queue
// Two-entry queue between the decode front end and the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire tcw_pkg::cmd_t in_cmd,
    output logic               out_valid,
    input  wire logic          out_ready,
    output tcw_pkg::cmd_t      out_cmd
);
    import tcw_pkg::*;

    localparam int DEPTH = 2;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule : tcw_queue

`default_nettype wire

// File: src/tcw_back.sv
// ----------------------------------------------------------------------------
// Text console writer execution side
// Keeps the cursor and the screen memory, runs scroll and clear sweeps and
// holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [tcw_pkg::ATTR_W-1:0]   cfg_wr_data,
    input  wire logic                         cmd_valid,
    output logic                              cmd_ready,
    input  wire tcw_pkg::cmd_t                cmd,
    output tcw_pkg::back_status_t             status,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [tcw_pkg::CURSOR_W-1:0]      m_cursor_position,
    output logic                              m_cell_written,
    output logic [tcw_pkg::CURSOR_W-1:0]      m_cell_index,
    output logic [tcw_pkg::CELL_W-1:0]        m_cell_value,
    output logic                              m_scrolled
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int POS_W = $clog2(CELLS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);

    localparam logic [COL_W-1:0] LAST_COL   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [POS_W-1:0] LAST_CELL  = POS_W'(CELLS - 1);
    localparam logic [POS_W-1:0] ROW_STEP   = POS_W'(COLUMNS);
    localparam logic [POS_W-1:0] BOTTOM_POS = POS_W'((ROWS - 1) * COLUMNS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_DRAIN,
        ST_FILL
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic                 clearing_reg;
    logic                 clearing_next;
    logic [ATTR_W-1:0]    attr_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [ROW_W-1:0]     row_next;
    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     col_next;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [POS_W-1:0]     sweep_reg;
    logic [POS_W-1:0]     sweep_next;
    logic                 pend_reg;
    logic                 pend_next;
    logic [POS_W-1:0]     pend_idx_reg;
    logic [POS_W-1:0]     pend_idx_next;

    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [POS_W-1:0]     res_pos_reg;
    logic [POS_W-1:0]     res_pos_next;
    logic                 res_written_reg;
    logic                 res_written_next;
    logic [POS_W-1:0]     res_idx_reg;
    logic [POS_W-1:0]     res_idx_next;
    logic [CELL_W-1:0]    res_value_reg;
    logic [CELL_W-1:0]    res_value_next;
    logic                 res_scrolled_reg;
    logic                 res_scrolled_next;

    logic [CELL_W-1:0]    screen_mem [CELLS];
    logic [CELL_W-1:0]    rd_data_reg;
    logic [POS_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [POS_W-1:0]     wr_addr;
    logic [CELL_W-1:0]    wr_data;

    logic                 take;
    logic                 scroll;
    logic [POS_W-1:0]     line_start;

    assign status.clearing = clearing_reg;
    assign status.busy     = (state_reg != ST_IDLE);

    assign take      = cmd_valid && (state_reg == ST_IDLE) && !clearing_reg &&
                       (!m_valid_reg || m_ready);
    assign cmd_ready = take;

    assign line_start = pos_reg - POS_W'(col_reg);
    assign rd_addr    = sweep_reg;

    // Cursor update and cell write for one request.
    always_comb begin
        row_next          = row_reg;
        col_next          = col_reg;
        pos_next          = pos_reg;
        scroll            = 1'b0;
        res_pos_next      = res_pos_reg;
        res_written_next  = 1'b0;
        res_idx_next      = '0;
        res_value_next    = '0;
        res_scrolled_next = 1'b0;
        unique case (cmd.op)
            OP_NEWLINE: begin
                col_next = '0;
                if (row_reg == LAST_ROW) begin
                    scroll = 1'b1;
                end else begin
                    row_next = row_reg + 1'b1;
                    pos_next = line_start + ROW_STEP;
                end
            end
            OP_BACKSPACE: begin
                // Backspace at the home position leaves everything as is.
                if (pos_reg != '0) begin
                    if (col_reg == '0) begin
                        row_next = row_reg - 1'b1;
                        col_next = LAST_COL;
                    end else begin
                        col_next = col_reg - 1'b1;
                    end
                    pos_next         = pos_reg - 1'b1;
                    res_written_next = 1'b1;
                    res_idx_next     = pos_reg - 1'b1;
                    res_value_next   = BLANK_CELL;
                end
            end
            OP_RETURN: begin
                col_next = '0;
                pos_next = line_start;
            end
            OP_IGNORE: begin
            end
            OP_PRINT: begin
                res_written_next = 1'b1;
                res_idx_next     = pos_reg;
                res_value_next   = {attr_reg, cmd.code};
                if (col_reg == LAST_COL) begin
                    col_next = '0;
                    if (row_reg == LAST_ROW) begin
                        scroll = 1'b1;
                    end else begin
                        row_next = row_reg + 1'b1;
                        pos_next = pos_reg + 1'b1;
                    end
                end else begin
                    col_next = col_reg + 1'b1;
                    pos_next = pos_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (scroll) begin
            row_next          = LAST_ROW;
            col_next          = '0;
            pos_next          = BOTTOM_POS;
            res_scrolled_next = 1'b1;
        end
        res_pos_next = pos_next;
    end

    // Sequencer for the scroll copy and the blank fill sweeps.
    always_comb begin
        state_next    = state_reg;
        clearing_next = clearing_reg;
        sweep_next    = sweep_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        wr_en         = 1'b0;
        wr_addr       = pend_idx_reg;
        wr_data       = rd_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    m_valid_next = 1'b1;
                    wr_en        = res_written_next;
                    wr_addr      = res_idx_next;
                    wr_data      = res_value_next;
                    if (scroll) begin
                        state_next = ST_COPY;
                        sweep_next = ROW_STEP;
                        pend_next  = 1'b0;
                    end
                end
            end
            ST_COPY: begin
                // Read one row down, write the previous read one row up.
                wr_en         = pend_reg;
                pend_next     = 1'b1;
                pend_idx_next = sweep_reg - ROW_STEP;
                if (sweep_reg == LAST_CELL) begin
                    state_next = ST_DRAIN;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                wr_en      = 1'b1;
                state_next = ST_FILL;
                sweep_next = BOTTOM_POS;
            end
            ST_FILL: begin
                wr_en   = 1'b1;
                wr_addr = sweep_reg;
                wr_data = BLANK_CELL;
                if (sweep_reg == LAST_CELL) begin
                    state_next    = ST_IDLE;
                    clearing_next = 1'b0;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_FILL;
            clearing_reg <= 1'b1;
            sweep_reg    <= '0;
            pend_reg     <= 1'b0;
            attr_reg     <= ATTR_W'(7);
            row_reg      <= '0;
            col_reg      <= '0;
            pos_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clearing_reg <= clearing_next;
            sweep_reg    <= sweep_next;
            pend_reg     <= pend_next;
            if (cfg_wr_en) begin
                attr_reg <= cfg_wr_data;
            end
            if (take) begin
                row_reg <= row_next;
                col_reg <= col_next;
                pos_reg <= pos_next;
            end
            m_valid_reg <= m_valid_next;
        end
        pend_idx_reg <= pend_idx_next;
        if (take) begin
            res_pos_reg      <= res_pos_next;
            res_written_reg  <= res_written_next;
            res_idx_reg      <= res_idx_next;
            res_value_reg    <= res_value_next;
            res_scrolled_reg <= res_scrolled_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            screen_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= screen_mem[rd_addr];
    end

    assign m_valid           = m_valid_reg;
    assign m_cursor_position = CURSOR_W'(res_pos_reg);
    assign m_cell_written    = res_written_reg;
    assign m_cell_index      = CURSOR_W'(res_idx_reg);
    assign m_cell_value      = res_value_reg;
    assign m_scrolled        = res_scrolled_reg;

endmodule : tcw_back

`default_nettype wire

// File: src/text_console_char_writer_unit.sv
// ----------------------------------------------------------------------------
// Text console character writer
// Character requests in, cursor and cell write reports out.
// ----------------------------------------------------------------------------
// Each request carries one character byte and returns exactly one result with
// the new cursor position, the cell written (if any) and a scroll flag. After
// reset the screen memory is cleared to blank, one cell per cycle; no request
// is taken during that time, while attribute writes are. An ordinary character
// passes the decode stage, the queue and the execution stage, and the block
// sustains one request per cycle while no scroll sweep runs and each result is
// taken. A request that scrolls the screen makes the execution side copy the
// memory up one row through its single read and write port and blank the
// bottom row, which holds it busy; up to three further requests are buffered
// in the front end and the queue meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [tcw_pkg::ATTR_W-1:0]   cfg_wr_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [tcw_pkg::CHAR_W-1:0]   s_char_code,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [tcw_pkg::CURSOR_W-1:0]      m_cursor_position,
    output logic                              m_cell_written,
    output logic [tcw_pkg::CURSOR_W-1:0]      m_cell_index,
    output logic [tcw_pkg::CELL_W-1:0]        m_cell_value,
    output logic                              m_scrolled
);
    import tcw_pkg::*;

    localparam logic [CURSOR_W-1:0] BOTTOM_LEFT = CURSOR_W'((ROWS - 1) * COLUMNS);

    back_status_t status;
    logic         push_valid;
    logic         push_ready;
    cmd_t         push_cmd;
    logic         q_valid;
    logic         q_ready;
    cmd_t         q_cmd;

    tcw_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .status      (status),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd)
    );

    tcw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_cmd    (push_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .cmd_valid         (q_valid),
        .cmd_ready         (q_ready),
        .cmd               (q_cmd),
        .status            (status),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cursor_position (m_cursor_position),
        .m_cell_written    (m_cell_written),
        .m_cell_index      (m_cell_index),
        .m_cell_value      (m_cell_value),
        .m_scrolled        (m_scrolled)
    );

    // No request enters while the screen is still being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.clearing |-> !s_ready)
        else $error("request accepted during the clearing sweep");

    // The execution side takes no command while a sweep is running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.busy |-> !q_ready)
        else $error("command taken during a scroll sweep");

    // A result without a cell write reports a zero index and value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_cell_written) |-> (m_cell_index == '0 && m_cell_value == '0))
        else $error("cell fields set without a cell write");

    // A scroll always leaves the cursor at the bottom-left cell.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_scrolled) |-> (m_cursor_position == BOTTOM_LEFT))
        else $error("scroll left the cursor off the bottom-left cell");

    // A scroll starts a sweep in the same cycle as its result is posted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready && !status.busy) ##1 (m_valid && m_scrolled && $rose(m_valid))
            |-> status.busy)
        else $error("scroll result posted without starting the copy");

endmodule : text_console_char_writer_unit

`default_nettype wire
